[rtl/fqkr_pkg.sv]
// ============================================================================
// fqkr_pkg
// Shared types and constants for the keyed-removal queue.
// ============================================================================
package fqkr_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_POP     = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOTFOUND  = 3'd2,
        ST_OLDEST    = 3'd3,
        ST_MOVED     = 3'd4,
        ST_UNDERFLOW = 3'd5,
        ST_POPPED    = 3'd6
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture command and identifier
        logic compare;   // register the match vector
        logic execute;   // update the queue and the result registers
    } ctrl_t;

endpackage

[rtl/fqkr_ctrl.sv]
// ============================================================================
// fqkr_ctrl
// Sequencer: accept, compare, execute, then report one result.
// ============================================================================
module fqkr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output fqkr_pkg::ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign ctrl.load    = (state_reg == S_IDLE) && start;
    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.execute = (state_reg == S_EXEC);
    assign busy         = busy_reg;
    assign done         = done_reg;

endmodule

[rtl/fqkr_dp.sv]
// ============================================================================
// fqkr_dp
// Entry cells, match compare, compaction shift and result registers.
// ============================================================================
module fqkr_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fqkr_pkg::ctrl_t              ctrl,
    input  logic [1:0]                   cmd,
    input  logic [fqkr_pkg::ID_W-1:0]    item_id,
    output logic [2:0]                   status,
    output logic [3:0]                   moved_count,
    output logic [4:0]                   occupancy
);

    logic [1:0]                  cmd_reg;
    logic [fqkr_pkg::ID_W-1:0]   id_reg;
    logic [fqkr_pkg::ID_W-1:0]   entries [fqkr_pkg::DEPTH];
    logic [fqkr_pkg::DEPTH-1:0]  match_reg;
    logic [fqkr_pkg::DEPTH-1:0]  match_next;
    logic [fqkr_pkg::CNT_W-1:0]  count_reg;
    logic [fqkr_pkg::CNT_W-1:0]  count_next;
    fqkr_pkg::status_t           status_reg;
    fqkr_pkg::status_t           status_next;
    logic [fqkr_pkg::IDX_W-1:0]  moved_reg;
    logic [fqkr_pkg::IDX_W-1:0]  moved_next;

    logic                        found;
    logic [fqkr_pkg::IDX_W-1:0]  hit_pos;
    logic                        enq_en;
    logic                        drop_en;
    logic [fqkr_pkg::IDX_W-1:0]  drop_pos;

    // capture the command
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            id_reg  <= item_id;
        end
    end

    // compare every occupied cell against the key at once
    always_comb
    begin
        for (int k = 0; k < fqkr_pkg::DEPTH; k++)
        begin
            match_next[k] = (entries[k] == id_reg) &&
                            (fqkr_pkg::CNT_W'(k) < count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.compare)
            match_reg <= match_next;
    end

    // newest match wins: the highest set index
    always_comb
    begin
        found   = 1'b0;
        hit_pos = '0;
        for (int k = 0; k < fqkr_pkg::DEPTH; k++)
        begin
            if (match_reg[k])
            begin
                found   = 1'b1;
                hit_pos = fqkr_pkg::IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        enq_en      = 1'b0;
        drop_en     = 1'b0;
        drop_pos    = '0;
        count_next  = count_reg;
        status_next = fqkr_pkg::ST_NOTFOUND;
        moved_next  = '0;
        case (cmd_reg)
            fqkr_pkg::CMD_ENQUEUE:
            begin
                if (count_reg >= fqkr_pkg::CNT_W'(fqkr_pkg::DEPTH))
                    status_next = fqkr_pkg::ST_FULL;
                else
                begin
                    enq_en      = 1'b1;
                    count_next  = count_reg + 1'b1;
                    status_next = fqkr_pkg::ST_ADDED;
                end
            end
            fqkr_pkg::CMD_REMOVE:
            begin
                if (found)
                begin
                    drop_en    = 1'b1;
                    drop_pos   = hit_pos;
                    count_next = count_reg - 1'b1;
                    if (hit_pos == '0)
                        status_next = fqkr_pkg::ST_OLDEST;
                    else
                    begin
                        status_next = fqkr_pkg::ST_MOVED;
                        moved_next  = hit_pos;
                    end
                end
            end
            fqkr_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                    status_next = fqkr_pkg::ST_UNDERFLOW;
                else
                begin
                    drop_en     = 1'b1;
                    count_next  = count_reg - 1'b1;
                    status_next = fqkr_pkg::ST_POPPED;
                end
            end
            default:
            begin
                status_next = fqkr_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // append at the back, or shift the cells above the gap down by one
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            if (enq_en)
                entries[count_reg[fqkr_pkg::IDX_W-1:0]] <= id_reg;
            else if (drop_en)
            begin
                for (int k = 0; k < fqkr_pkg::DEPTH - 1; k++)
                begin
                    if (fqkr_pkg::IDX_W'(k) >= drop_pos)
                        entries[k] <= entries[k + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.execute)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            status_reg <= status_next;
            moved_reg  <= moved_next;
        end
    end

    assign status      = status_reg;
    assign moved_count = 4'(moved_reg);
    assign occupancy   = 5'(count_reg);

endmodule

[rtl/fifo_queue_with_keyed_removal_core.sv]
// ============================================================================
// fifo_queue_with_keyed_removal_core
// Ordered queue of 16-bit identifiers with enqueue, pop and removal by key.
// ============================================================================
// Usage:
//   Command channel: drive cmd and item_id and raise start; the item is taken
//   at a rising edge where start is high and busy is low.
//   cmd 0 appends item_id at the back (status full when 16 entries are held),
//   cmd 1 deletes the newest entry equal to item_id and keeps the order of the
//   rest, cmd 2 drops the oldest entry. Code 3 changes nothing and reports
//   not found.
//   Result channel: done is high for exactly one cycle with status,
//   moved_count (entries older than the removed one) and occupancy
//   (entries held after the command). The receiver cannot stall; sample the
//   result in the cycle that done is high.
//   Timing: items are taken one at a time, not while busy is high. The item is
//   captured, the match vector over all 16 cells is registered in the next
//   cycle, and in the execute state the newest match is picked and the cells
//   compact in one shift. done rises in the cycle after that, the same cycle
//   busy falls, so a new item can be taken while the result is shown.
//   Reset: rst_n clears the occupancy and the sequencer; cell contents are
//   left as they are since slots above the occupancy are never read.
// ============================================================================
module fifo_queue_with_keyed_removal_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] item_id,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  moved_count,
    output logic [4:0]  occupancy
);

    // command bundle from the sequencer to the datapath
    fqkr_pkg::ctrl_t ctrl;

    // sequence each item through capture, compare and execute
    fqkr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // hold the cells, compare against the key, compact and report
    fqkr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (cmd),
        .item_id     (item_id),
        .status      (status),
        .moved_count (moved_count),
        .occupancy   (occupancy)
    );

endmodule
